>>> rtl/core/four_voice_sound_unit_defines.svh
// Assertion macros shared by the sound unit RTL
`ifndef FOUR_VOICE_SOUND_UNIT_DEFINES_SVH
`define FOUR_VOICE_SOUND_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define FVSU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define FVSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/fvsu_pkg.sv
// Shared types, register addresses and small tables of the sound unit
`default_nettype none

package fvsu_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_SAMPLE_STEP = 2'd0,
    CFG_SAMPLE_MOD  = 2'd1,
    CFG_FRAME_STEP  = 2'd2
  } cfg_e;

  localparam logic [15:0] ADDR_SWEEP      = 16'hFF10;
  localparam logic [15:0] ADDR_P1_LEN     = 16'hFF11;
  localparam logic [15:0] ADDR_P1_ENV     = 16'hFF12;
  localparam logic [15:0] ADDR_P1_LO      = 16'hFF13;
  localparam logic [15:0] ADDR_P1_HI      = 16'hFF14;
  localparam logic [15:0] ADDR_P2_LEN     = 16'hFF16;
  localparam logic [15:0] ADDR_P2_ENV     = 16'hFF17;
  localparam logic [15:0] ADDR_P2_LO      = 16'hFF18;
  localparam logic [15:0] ADDR_P2_HI      = 16'hFF19;
  localparam logic [15:0] ADDR_WAVE_DAC   = 16'hFF1A;
  localparam logic [15:0] ADDR_WAVE_LEN   = 16'hFF1B;
  localparam logic [15:0] ADDR_WAVE_LVL   = 16'hFF1C;
  localparam logic [15:0] ADDR_WAVE_LO    = 16'hFF1D;
  localparam logic [15:0] ADDR_WAVE_HI    = 16'hFF1E;
  localparam logic [15:0] ADDR_NOISE_LEN  = 16'hFF20;
  localparam logic [15:0] ADDR_NOISE_ENV  = 16'hFF21;
  localparam logic [15:0] ADDR_NOISE_POLY = 16'hFF22;
  localparam logic [15:0] ADDR_NOISE_CTRL = 16'hFF23;
  localparam logic [15:0] ADDR_MIX_VOL    = 16'hFF24;
  localparam logic [15:0] ADDR_MIX_ROUTE  = 16'hFF25;
  localparam logic [15:0] ADDR_POWER      = 16'hFF26;
  localparam logic [11:0] ADDR_WAVE_PAGE  = 12'hFF3;

  localparam logic [7:0] STATUS_FILL = 8'h70;
  localparam logic [7:0] READ_NONE   = 8'hFF;
  localparam logic [14:0] LFSR_SEED  = 15'h7FFF;

  localparam int unsigned WAVE_BYTES = 16;
  localparam int unsigned OUT_DEPTH  = 3;
  localparam int unsigned PHASE_W    = 24;
  localparam int unsigned DIV_STEPS  = PHASE_W + 1;

  // Duty waveform for a select code, one bit per step
  function automatic logic [7:0] duty_pattern(input logic [1:0] sel);
    logic [7:0] pat;
    case (sel)
      2'd0:    pat = 8'h80;
      2'd1:    pat = 8'hC0;
      2'd2:    pat = 8'hF0;
      default: pat = 8'h3F;
    endcase
    return pat;
  endfunction

  // Pulse timer reload: (2048 - f) * 4
  function automatic logic [13:0] pulse_period(input logic [10:0] f);
    logic [11:0] diff;
    diff = 12'h800 - {1'b0, f};
    return {diff, 2'b00};
  endfunction

  // Wave timer reload: (2048 - f) * 2
  function automatic logic [13:0] wave_period(input logic [10:0] f);
    logic [11:0] diff;
    diff = 12'h800 - {1'b0, f};
    return {1'b0, diff, 1'b0};
  endfunction

  // Noise timer reload: divisor shifted by the clock shift, capped at 16 bits
  function automatic logic [15:0] noise_period(input logic [2:0] code,
                                               input logic [3:0] shift);
    logic [6:0]  div;
    logic [21:0] p;
    case (code)
      3'd0:    div = 7'd8;
      3'd1:    div = 7'd16;
      3'd2:    div = 7'd32;
      3'd3:    div = 7'd48;
      3'd4:    div = 7'd64;
      3'd5:    div = 7'd80;
      3'd6:    div = 7'd96;
      default: div = 7'd112;
    endcase
    p = {15'd0, div} << shift;
    return (p > 22'h00FFFF) ? 16'hFFFF : p[15:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/fvsu_ram.sv
// Generic RAM: one write port, two registered read ports
`default_nettype none

module fvsu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and read, read data registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

>>> rtl/core/four_voice_sound_unit.sv
// A read or sample transaction is registered, then its result enters the output queue.
// Throughput: one transaction per cycle while in_stall_o is low; the state registers update
// in a single pass per tick. A tick whose phase sum reaches twice the modulus (out-of-range
// settings) runs a remainder unit that holds off input until the phase is reduced.
// Reset: asynchronous, active low; channels off, master enable on, config at default values,
// wave RAM reads zero until written.
`default_nettype none
`include "four_voice_sound_unit_defines.svh"

module four_voice_sound_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [15:0] address_i,
  input  wire logic [7:0]  write_data_i,
  // output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             result_kind_o,
  output logic [7:0]       read_data_o,
  output logic [15:0]      mixed_sample_o,
  output logic [15:0]      pulse_one_stem_o,
  output logic [15:0]      pulse_two_stem_o,
  output logic [15:0]      wave_stem_o,
  output logic [15:0]      noise_stem_o,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  typedef struct packed {
    logic             master_en;
    logic [15:0]      frame_cnt;
    logic [2:0]       frame_step;
    logic [2:0][10:0] tone_freq;
    logic [2:0][13:0] tone_timer;
    logic [1:0][2:0]  duty_pos;
    logic [1:0][1:0]  duty_sel;
    logic [3:0][8:0]  len_cnt;
    logic [3:0]       len_en;
    logic [3:0]       ch_on;
    logic [3:0]       dac_on;
    logic [2:0][3:0]  env_vol;
    logic [2:0][3:0]  env_init;
    logic [2:0][2:0]  env_per;
    logic [2:0][2:0]  env_timer;
    logic [2:0]       env_rise;
    logic [2:0]       sweep_per;
    logic [2:0]       sweep_shift;
    logic             sweep_neg;
    logic             sweep_act;
    logic [2:0]       sweep_timer;
    logic [10:0]      shadow_freq;
    logic [4:0]       wave_pos;
    logic [1:0]       wave_lvl;
    logic [15:0]      noise_timer;
    logic [14:0]      lfsr;
    logic [3:0]       noise_shift;
    logic [2:0]       noise_div;
    logic             noise_short;
    logic [7:0]       mix_vol;
    logic [7:0]       mix_route;
  } apu_state_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  rdata;
    logic [15:0] mix;
    logic [3:0][15:0] stem;
  } out_item_t;

  fvsu_pkg::cmd_e cmd;
  logic           in_acc;

  // Configuration registers
  logic [21:0] cfg_step_q;
  logic [23:0] cfg_mod_q;
  logic [15:0] cfg_frame_q;
  logic        cfg_wr;

  // Sound state
  apu_state_t st_q, st_d;
  logic [15:0] fcc_inc;
  logic [10:0] sw_delta;
  logic [11:0] sw_new;
  logic [13:0] tmr;
  logic [15:0] ntmr;
  logic        nfb;
  logic [14:0] nlfsr;
  logic        hi_idx;
  logic [1:0]  env_ch;
  logic [1:0]  env_idx;

  // Wave RAM
  logic [15:0] wave_vld_q;
  logic        vld_a_q, vld_b_q;
  logic        wave_we;
  logic [7:0]  ram_a, ram_b;

  // Phase accumulator and remainder unit
  logic [PHASE_MSB:0] phase_q, phase_d;
  localparam int unsigned PHASE_MSB = fvsu_pkg::PHASE_W - 1;
  logic [fvsu_pkg::PHASE_W:0]   phase_sum;
  logic [fvsu_pkg::PHASE_W:0]   phase_sub;
  logic                         emit;
  logic                         div_start;
  logic                         div_busy_q;
  logic [4:0]                   div_cnt_q;
  logic [fvsu_pkg::PHASE_W:0]   div_num_q;
  logic [PHASE_MSB:0]           div_rem_q;
  logic [PHASE_MSB:0]           div_mod_q;
  logic [fvsu_pkg::PHASE_W:0]   div_try;
  logic [fvsu_pkg::PHASE_W:0]   div_next;

  // Result stage
  logic       pend_q;
  logic       pend_kind_q;
  logic       pend_wave_q;
  logic [7:0] pend_rdata_q;
  logic [7:0] rd_now;
  logic       rd_wave;
  out_item_t  item;
  logic signed [5:0] raw [4];
  logic [3:0]  lv, rv;
  logic [15:0] lx, rx;
  logic [7:0]  wbyte;
  logic [3:0]  wnib;
  logic [3:0]  wsh;
  logic [5:0]  wval;

  // Output queue
  out_item_t fifo_q [fvsu_pkg::OUT_DEPTH];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign cmd    = fvsu_pkg::cmd_e'(command_i);
  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = div_busy_q || (({1'b0, cnt_q} + {2'b0, pend_q}) >= 3'd3);

  // ---------------------------------------------------------------- config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[3:2])
      fvsu_pkg::CFG_SAMPLE_STEP: prdata = {10'd0, cfg_step_q};
      fvsu_pkg::CFG_SAMPLE_MOD:  prdata = {8'd0, cfg_mod_q};
      fvsu_pkg::CFG_FRAME_STEP:  prdata = {16'd0, cfg_frame_q};
      default:                   prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_step_q  <= 22'd48000;
      cfg_mod_q   <= 24'd4194304;
      cfg_frame_q <= 16'd8192;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        fvsu_pkg::CFG_SAMPLE_STEP: cfg_step_q  <= pwdata[21:0];
        fvsu_pkg::CFG_SAMPLE_MOD:  cfg_mod_q   <= pwdata[23:0];
        fvsu_pkg::CFG_FRAME_STEP:  cfg_frame_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- state update
  always_comb begin
    st_d     = st_q;
    fcc_inc  = st_q.frame_cnt + 16'd1;
    sw_delta = '0;
    sw_new   = '0;
    tmr      = '0;
    ntmr     = '0;
    nfb      = 1'b0;
    nlfsr    = '0;
    hi_idx   = 1'b0;
    env_ch   = '0;
    env_idx  = '0;

    if (in_acc && cmd == fvsu_pkg::CMD_TICK && st_q.master_en) begin
      // Frame sequencer
      if (fcc_inc >= cfg_frame_q) begin
        st_d.frame_cnt = '0;
        if (!st_q.frame_step[0]) begin
          for (int c = 0; c < 4; c++) begin
            if (st_q.len_en[c] && st_q.len_cnt[c] != 9'd0) begin
              st_d.len_cnt[c] = st_q.len_cnt[c] - 9'd1;
              if (st_d.len_cnt[c] == 9'd0) st_d.ch_on[c] = 1'b0;
            end
          end
          // Sweep on steps two and six
          if (st_q.frame_step[1] && st_q.sweep_act && st_q.sweep_per != 3'd0 &&
              st_q.sweep_shift != 3'd0) begin
            if (st_q.sweep_timer > 3'd1) begin
              st_d.sweep_timer = st_q.sweep_timer - 3'd1;
            end else begin
              st_d.sweep_timer = st_q.sweep_per;
              sw_delta = st_q.shadow_freq >> st_q.sweep_shift;
              sw_new   = st_q.sweep_neg ? {1'b0, st_q.shadow_freq} - {1'b0, sw_delta}
                                        : {1'b0, st_q.shadow_freq} + {1'b0, sw_delta};
              if (sw_new[11]) begin
                st_d.ch_on[0] = 1'b0;
              end else begin
                st_d.shadow_freq  = sw_new[10:0];
                st_d.tone_freq[0] = sw_new[10:0];
              end
            end
          end
        end else if (st_q.frame_step == 3'd7) begin
          // Envelopes on the last step
          for (int e = 0; e < 3; e++) begin
            if (st_q.env_per[e] != 3'd0) begin
              if (st_q.env_timer[e] > 3'd1) begin
                st_d.env_timer[e] = st_q.env_timer[e] - 3'd1;
              end else begin
                st_d.env_timer[e] = st_q.env_per[e];
                if (st_q.env_rise[e]) begin
                  if (st_q.env_vol[e] != 4'd15) st_d.env_vol[e] = st_q.env_vol[e] + 4'd1;
                end else if (st_q.env_vol[e] != 4'd0) begin
                  st_d.env_vol[e] = st_q.env_vol[e] - 4'd1;
                end
              end
            end
          end
        end
        st_d.frame_step = st_q.frame_step + 3'd1;
      end else begin
        st_d.frame_cnt = fcc_inc;
      end

      // Pulse timers
      for (int c = 0; c < 2; c++) begin
        tmr = st_q.tone_timer[c];
        if (tmr != 14'd0) tmr = tmr - 14'd1;
        if (tmr == 14'd0) begin
          tmr = fvsu_pkg::pulse_period(st_d.tone_freq[c]);
          st_d.duty_pos[c] = st_q.duty_pos[c] + 3'd1;
        end
        st_d.tone_timer[c] = tmr;
      end

      // Wave timer
      tmr = st_q.tone_timer[2];
      if (tmr != 14'd0) tmr = tmr - 14'd1;
      if (tmr == 14'd0) begin
        tmr = fvsu_pkg::wave_period(st_q.tone_freq[2]);
        st_d.wave_pos = st_q.wave_pos + 5'd1;
      end
      st_d.tone_timer[2] = tmr;

      // Noise timer and shift register
      ntmr = st_q.noise_timer;
      if (ntmr != 16'd0) ntmr = ntmr - 16'd1;
      if (ntmr == 16'd0) begin
        ntmr  = fvsu_pkg::noise_period(st_q.noise_div, st_q.noise_shift);
        nfb   = st_q.lfsr[0] ^ st_q.lfsr[1];
        nlfsr = {nfb, st_q.lfsr[14:1]};
        if (st_q.noise_short) nlfsr[6] = nfb;
        st_d.lfsr = nlfsr;
      end
      st_d.noise_timer = ntmr;
    end

    if (in_acc && cmd == fvsu_pkg::CMD_WRITE) begin
      if (address_i == fvsu_pkg::ADDR_POWER) begin
        if (write_data_i[7]) begin
          st_d.master_en = 1'b1;
        end else begin
          // Power off: clear channels and mixer, keep the sequencer counters
          st_d            = '0;
          st_d.frame_cnt  = st_q.frame_cnt;
          st_d.frame_step = st_q.frame_step;
        end
      end else if (st_q.master_en) begin
        unique case (address_i)
          fvsu_pkg::ADDR_SWEEP: begin
            st_d.sweep_per   = write_data_i[6:4];
            st_d.sweep_neg   = write_data_i[3];
            st_d.sweep_shift = write_data_i[2:0];
            st_d.sweep_act   = (write_data_i[6:4] != 3'd0) || (write_data_i[2:0] != 3'd0);
          end
          fvsu_pkg::ADDR_P1_LEN, fvsu_pkg::ADDR_P2_LEN: begin
            hi_idx = (address_i == fvsu_pkg::ADDR_P2_LEN);
            st_d.duty_sel[hi_idx] = write_data_i[7:6];
            st_d.len_cnt[hi_idx]  = 9'd64 - {3'd0, write_data_i[5:0]};
          end
          fvsu_pkg::ADDR_P1_ENV, fvsu_pkg::ADDR_P2_ENV, fvsu_pkg::ADDR_NOISE_ENV: begin
            env_ch  = (address_i == fvsu_pkg::ADDR_P1_ENV) ? 2'd0 :
                      (address_i == fvsu_pkg::ADDR_P2_ENV) ? 2'd1 : 2'd3;
            env_idx = (env_ch == 2'd3) ? 2'd2 : env_ch;
            st_d.dac_on[env_ch] = (write_data_i[7:3] != 5'd0);
            if (write_data_i[7:3] == 5'd0) st_d.ch_on[env_ch] = 1'b0;
            st_d.env_rise[env_idx]  = write_data_i[3];
            st_d.env_per[env_idx]   = write_data_i[2:0];
            st_d.env_init[env_idx]  = write_data_i[7:4];
            st_d.env_vol[env_idx]   = write_data_i[7:4];
            st_d.env_timer[env_idx] = write_data_i[2:0];
          end
          fvsu_pkg::ADDR_P1_LO: st_d.tone_freq[0][7:0] = write_data_i;
          fvsu_pkg::ADDR_P2_LO: st_d.tone_freq[1][7:0] = write_data_i;
          fvsu_pkg::ADDR_WAVE_LO: st_d.tone_freq[2][7:0] = write_data_i;
          fvsu_pkg::ADDR_P1_HI, fvsu_pkg::ADDR_P2_HI: begin
            hi_idx = (address_i == fvsu_pkg::ADDR_P2_HI);
            st_d.tone_freq[hi_idx][10:8] = write_data_i[2:0];
            st_d.len_en[hi_idx] = write_data_i[6];
            if (write_data_i[7]) begin
              if (st_q.len_cnt[hi_idx] == 9'd0) st_d.len_cnt[hi_idx] = 9'd64;
              st_d.env_vol[hi_idx]    = st_q.env_init[hi_idx];
              st_d.env_timer[hi_idx]  = st_q.env_per[hi_idx];
              st_d.duty_pos[hi_idx]   = '0;
              st_d.tone_timer[hi_idx] = fvsu_pkg::pulse_period(st_d.tone_freq[hi_idx]);
              st_d.ch_on[hi_idx]      = st_q.dac_on[hi_idx];
              if (!hi_idx) begin
                st_d.sweep_act   = (st_q.sweep_per != 3'd0) || (st_q.sweep_shift != 3'd0);
                st_d.shadow_freq = st_d.tone_freq[0];
                st_d.sweep_timer = st_q.sweep_per;
              end
            end
          end
          fvsu_pkg::ADDR_WAVE_DAC: begin
            st_d.dac_on[2] = write_data_i[7];
            if (!write_data_i[7]) st_d.ch_on[2] = 1'b0;
          end
          fvsu_pkg::ADDR_WAVE_LEN: st_d.len_cnt[2] = 9'd256 - {1'b0, write_data_i};
          fvsu_pkg::ADDR_WAVE_LVL: st_d.wave_lvl = write_data_i[6:5];
          fvsu_pkg::ADDR_WAVE_HI: begin
            st_d.tone_freq[2][10:8] = write_data_i[2:0];
            st_d.len_en[2] = write_data_i[6];
            if (write_data_i[7]) begin
              if (st_q.len_cnt[2] == 9'd0) st_d.len_cnt[2] = 9'd256;
              st_d.ch_on[2]      = st_q.dac_on[2];
              st_d.tone_timer[2] = fvsu_pkg::wave_period(st_d.tone_freq[2]);
              st_d.wave_pos      = '0;
            end
          end
          fvsu_pkg::ADDR_NOISE_LEN: st_d.len_cnt[3] = 9'd64 - {3'd0, write_data_i[5:0]};
          fvsu_pkg::ADDR_NOISE_POLY: begin
            st_d.noise_shift = write_data_i[7:4];
            st_d.noise_div   = write_data_i[2:0];
            st_d.noise_short = write_data_i[3];
          end
          fvsu_pkg::ADDR_NOISE_CTRL: begin
            st_d.len_en[3] = write_data_i[6];
            if (write_data_i[7]) begin
              if (st_q.len_cnt[3] == 9'd0) st_d.len_cnt[3] = 9'd64;
              st_d.ch_on[3]     = st_q.dac_on[3];
              st_d.env_vol[2]   = st_q.env_init[2];
              st_d.env_timer[2] = st_q.env_per[2];
              st_d.lfsr         = fvsu_pkg::LFSR_SEED;
              st_d.noise_timer  = fvsu_pkg::noise_period(st_q.noise_div, st_q.noise_shift);
            end
          end
          fvsu_pkg::ADDR_MIX_VOL:   st_d.mix_vol   = write_data_i;
          fvsu_pkg::ADDR_MIX_ROUTE: st_d.mix_route = write_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q           <= '0;
      st_q.master_en <= 1'b1;
    end else begin
      st_q <= st_d;
    end
  end

  // ---------------------------------------------------------------- wave RAM
  assign wave_we = in_acc && cmd == fvsu_pkg::CMD_WRITE &&
                   address_i[15:4] == fvsu_pkg::ADDR_WAVE_PAGE;

  fvsu_ram #(
    .WIDTH (8),
    .DEPTH (fvsu_pkg::WAVE_BYTES)
  ) u_wave_ram (
    .clk_i     (clk_i),
    .we_i      (wave_we),
    .waddr_i   (address_i[3:0]),
    .wdata_i   (write_data_i),
    .raddr_a_i (st_d.wave_pos[4:1]),
    .rdata_a_o (ram_a),
    .raddr_b_i (address_i[3:0]),
    .rdata_b_o (ram_b)
  );

  // Track written bytes; unwritten bytes read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_vld_q <= '0;
      vld_a_q    <= 1'b0;
      vld_b_q    <= 1'b0;
    end else begin
      if (wave_we) wave_vld_q[address_i[3:0]] <= 1'b1;
      vld_a_q <= wave_vld_q[st_d.wave_pos[4:1]];
      vld_b_q <= wave_vld_q[address_i[3:0]];
    end
  end

  // ---------------------------------------------------------------- sample phase
  assign phase_sum = {1'b0, phase_q} + {3'd0, cfg_step_q};
  assign phase_sub = phase_sum - {1'b0, cfg_mod_q};
  assign div_try   = {div_rem_q, div_num_q[fvsu_pkg::PHASE_W]};
  assign div_next  = (div_try >= {1'b0, div_mod_q}) ? div_try - {1'b0, div_mod_q} : div_try;

  always_comb begin
    phase_d   = phase_q;
    emit      = 1'b0;
    div_start = 1'b0;
    if (in_acc && cmd == fvsu_pkg::CMD_TICK) begin
      if (cfg_mod_q == '0) begin
        phase_d = '0;
        emit    = 1'b1;
      end else if (phase_sum < {1'b0, cfg_mod_q}) begin
        phase_d = phase_sum[PHASE_MSB:0];
      end else begin
        emit = 1'b1;
        if (phase_sub < {1'b0, cfg_mod_q}) begin
          phase_d = phase_sub[PHASE_MSB:0];
        end else begin
          div_start = 1'b1;
        end
      end
    end else if (div_busy_q && div_cnt_q == 5'd1) begin
      phase_d = div_next[PHASE_MSB:0];
    end
  end

  // Remainder unit: one dividend bit per cycle, modulus held from the start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= '0;
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
    end else begin
      phase_q <= phase_d;
      if (div_start) begin
        div_busy_q <= 1'b1;
        div_cnt_q  <= 5'(fvsu_pkg::DIV_STEPS);
      end else if (div_busy_q) begin
        div_cnt_q <= div_cnt_q - 5'd1;
        if (div_cnt_q == 5'd1) div_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      div_num_q <= phase_sum;
      div_rem_q <= '0;
      div_mod_q <= cfg_mod_q;
    end else if (div_busy_q) begin
      div_num_q <= {div_num_q[fvsu_pkg::PHASE_W-1:0], 1'b0};
      div_rem_q <= div_next[PHASE_MSB:0];
    end
  end

  // ---------------------------------------------------------------- read decode
  always_comb begin
    rd_wave = address_i[15:4] == fvsu_pkg::ADDR_WAVE_PAGE;
    unique case (address_i)
      fvsu_pkg::ADDR_MIX_VOL:   rd_now = st_q.mix_vol;
      fvsu_pkg::ADDR_MIX_ROUTE: rd_now = st_q.mix_route;
      fvsu_pkg::ADDR_POWER:     rd_now = fvsu_pkg::STATUS_FILL |
                                         {st_q.master_en, 3'd0, st_q.ch_on};
      default:                  rd_now = fvsu_pkg::READ_NONE;
    endcase
  end

  // Hold the transaction that owes a result for one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= in_acc && ((cmd == fvsu_pkg::CMD_READ) || emit);
    end
  end

  always_ff @(posedge clk_i) begin
    pend_kind_q  <= (cmd == fvsu_pkg::CMD_READ);
    pend_wave_q  <= rd_wave;
    pend_rdata_q <= rd_now;
  end

  // ---------------------------------------------------------------- mixer
  always_comb begin
    wbyte = vld_a_q ? ram_a : 8'd0;
    wnib  = st_q.wave_pos[0] ? wbyte[3:0] : wbyte[7:4];
    wsh   = wnib >> (st_q.wave_lvl - 2'd1);
    wval  = {({2'b0, wsh} - 6'd8)} << 1;

    for (int c = 0; c < 2; c++) begin
      if (!st_q.master_en || !st_q.ch_on[c] || !st_q.dac_on[c] || st_q.env_vol[c] == 4'd0)
        raw[c] = '0;
      else if (fvsu_pkg::duty_pattern(st_q.duty_sel[c])[st_q.duty_pos[c]])
        raw[c] = signed'({2'b0, st_q.env_vol[c]});
      else
        raw[c] = signed'(6'd0 - {2'b0, st_q.env_vol[c]});
    end

    if (!st_q.master_en || !st_q.ch_on[2] || !st_q.dac_on[2] || st_q.wave_lvl == 2'd0)
      raw[2] = '0;
    else
      raw[2] = signed'(wval);

    if (!st_q.master_en || !st_q.ch_on[3] || !st_q.dac_on[3] || st_q.env_vol[2] == 4'd0)
      raw[3] = '0;
    else if (st_q.lfsr[0])
      raw[3] = signed'(6'd0 - {2'b0, st_q.env_vol[2]});
    else
      raw[3] = signed'({2'b0, st_q.env_vol[2]});

    lv = {1'b0, st_q.mix_vol[6:4]} + 4'd1;
    rv = {1'b0, st_q.mix_vol[2:0]} + 4'd1;

    // Stems stay within 16 bits: at most 16 * 16 * 32 in magnitude
    item = '0;
    lx   = '0;
    rx   = '0;
    if (pend_kind_q) begin
      item.kind  = 1'b1;
      item.rdata = pend_wave_q ? (vld_b_q ? ram_b : 8'd0) : pend_rdata_q;
    end else begin
      for (int v = 0; v < 4; v++) begin
        lx = st_q.mix_route[4 + v] ? {{10{raw[v][5]}}, raw[v]} : 16'd0;
        rx = st_q.mix_route[v]     ? {{10{raw[v][5]}}, raw[v]} : 16'd0;
        item.stem[v] = (lx * {12'd0, lv} + rx * {12'd0, rv}) << 5;
        item.mix     = item.mix + item.stem[v];
      end
    end
  end

  // ---------------------------------------------------------------- output queue
  assign pop = (cnt_q != 2'd0) && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (pend_q) wr_ptr_q <= (wr_ptr_q == 2'(fvsu_pkg::OUT_DEPTH - 1)) ? 2'd0 : wr_ptr_q + 2'd1;
      if (pop)    rd_ptr_q <= (rd_ptr_q == 2'(fvsu_pkg::OUT_DEPTH - 1)) ? 2'd0 : rd_ptr_q + 2'd1;
      cnt_q <= cnt_q + {1'b0, pend_q} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_q) fifo_q[wr_ptr_q] <= item;
  end

  assign out_valid_o      = cnt_q != 2'd0;
  assign result_kind_o    = fifo_q[rd_ptr_q].kind;
  assign read_data_o      = fifo_q[rd_ptr_q].rdata;
  assign mixed_sample_o   = fifo_q[rd_ptr_q].mix;
  assign pulse_one_stem_o = fifo_q[rd_ptr_q].stem[0];
  assign pulse_two_stem_o = fifo_q[rd_ptr_q].stem[1];
  assign wave_stem_o      = fifo_q[rd_ptr_q].stem[2];
  assign noise_stem_o     = fifo_q[rd_ptr_q].stem[3];

  // ---------------------------------------------------------------- assertions
  `FVSU_ASSERT_NOW(a_queue_bound, clk_i, rst_ni, 1'b1, cnt_q <= 2'(fvsu_pkg::OUT_DEPTH),
                   "output queue count out of range")
  `FVSU_ASSERT_NOW(a_queue_room, clk_i, rst_ni, pend_q,
                   cnt_q < 2'(fvsu_pkg::OUT_DEPTH) || pop, "result pushed into full queue")
  `FVSU_ASSERT_NOW(a_div_stalls, clk_i, rst_ni, div_busy_q, in_stall_o,
                   "input accepted while phase remainder in progress")
  `FVSU_ASSERT_NEXT(a_div_ends, clk_i, rst_ni, div_busy_q && div_cnt_q == 5'd1, !div_busy_q,
                    "remainder unit did not finish")
  `FVSU_ASSERT_NOW(a_read_silent, clk_i, rst_ni, out_valid_o && result_kind_o,
                   mixed_sample_o == 16'd0 && noise_stem_o == 16'd0,
                   "read result carries sample data")

endmodule

`default_nettype wire

>>> sim/four_voice_sound_unit_tb.sv
// Self-checking testbench for the four-voice sound unit: directed table, then random phases
`default_nettype none

module four_voice_sound_unit_tb;
  import fvsu_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned HOLDOFF_CYCLES = 400;

  typedef struct packed {
    logic        kind;
    logic [7:0]  rd;
    logic [15:0] mix;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] wv;
    logic [15:0] nz;
  } sound_result_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        typed;
    logic [7:0]  rd;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  command_i = CMD_TICK;
  logic [15:0] address_i = '0;
  logic [7:0]  write_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        result_kind_o;
  logic [7:0]  read_data_o;
  logic [15:0] mixed_sample_o, pulse_one_stem_o, pulse_two_stem_o, wave_stem_o, noise_stem_o;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // typed expectation carried along with the payload in the directed part
  logic        row_typed = 1'b0;
  logic [7:0]  row_rd = '0;

  four_voice_sound_unit u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .command_i, .address_i, .write_data_i,
    .out_valid_o, .out_stall_i, .result_kind_o, .read_data_o, .mixed_sample_o,
    .pulse_one_stem_o, .pulse_two_stem_o, .wave_stem_o, .noise_stem_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------- sound unit shadow state ----------------
  bit [21:0] rate_step;
  bit [23:0] rate_mod;
  bit [15:0] seq_period;
  bit        pwr_on;
  bit [15:0] seq_count;
  bit [2:0]  seq_pos;
  bit [31:0] phase_acc;
  bit [10:0] freq[3];
  bit [13:0] freq_timer[3];
  bit [2:0]  duty_pos[2];
  bit [1:0]  duty_sel[2];
  bit [8:0]  len_cnt[4];
  bit        len_en[4], voice_on[4], dac_en[4];
  bit [3:0]  vol[3], vol_init[3];
  bit [2:0]  vol_period[3];
  bit [7:0]  vol_timer[3];
  bit        vol_up[3];
  bit [2:0]  sw_period, sw_shift;
  bit        sw_neg, sw_act;
  bit [7:0]  sw_timer;
  bit [10:0] sw_shadow;
  bit [4:0]  wpos;
  bit [1:0]  wlevel;
  bit [7:0]  wram[16];
  bit [15:0] lfsr_timer;
  bit [14:0] lfsr;
  bit [3:0]  lfsr_shift;
  bit [2:0]  lfsr_code;
  bit        lfsr_short;
  bit [7:0]  master_vol, routing;

  sound_result_t expected_q[$];

  function automatic bit [13:0] pulse_reload(bit [10:0] f);
    return 14'((2048 - int'(f)) * 4);
  endfunction

  function automatic bit [13:0] wave_reload(bit [10:0] f);
    return 14'((2048 - int'(f)) * 2);
  endfunction

  function automatic bit [15:0] lfsr_reload();
    int unsigned divs[8] = '{8, 16, 32, 48, 64, 80, 96, 112};
    longint unsigned p;
    p = longint'(divs[lfsr_code]) << lfsr_shift;
    if (p > 65535) p = 65535;
    return 16'(p);
  endfunction

  function automatic void clear_voices();
    for (int i = 0; i < 3; i++) begin
      freq[i] = 0; freq_timer[i] = 0; vol[i] = 0; vol_init[i] = 0;
      vol_period[i] = 0; vol_timer[i] = 0; vol_up[i] = 0;
    end
    for (int i = 0; i < 4; i++) begin
      len_cnt[i] = 0; len_en[i] = 0; voice_on[i] = 0; dac_en[i] = 0;
    end
    duty_pos = '{0, 0}; duty_sel = '{0, 0};
    sw_period = 0; sw_shift = 0; sw_neg = 0; sw_act = 0; sw_timer = 0; sw_shadow = 0;
    wpos = 0; wlevel = 0;
    lfsr_timer = 0; lfsr = 0; lfsr_shift = 0; lfsr_code = 0; lfsr_short = 0;
    master_vol = 0; routing = 0;
  endfunction

  function automatic void env_tick(int e);
    if (vol_period[e] == 0) return;
    if (vol_timer[e] > 1) begin
      vol_timer[e]--;
      return;
    end
    vol_timer[e] = vol_period[e];
    if (vol_up[e]) begin
      if (vol[e] < 15) vol[e]++;
    end else if (vol[e] > 0) vol[e]--;
  endfunction

  function automatic void frame_advance();
    bit [11:0] nf;
    if (seq_pos[0] == 1'b0) begin
      for (int c = 0; c < 4; c++) begin
        if (len_en[c] && len_cnt[c] > 0) begin
          len_cnt[c]--;
          if (len_cnt[c] == 0) voice_on[c] = 0;
        end
      end
      // frequency sweep on steps 2 and 6
      if ((seq_pos == 2 || seq_pos == 6) && sw_act && sw_period != 0 && sw_shift != 0) begin
        if (sw_timer > 1) sw_timer--;
        else begin
          sw_timer = sw_period;
          nf = sw_neg ? {1'b0, sw_shadow} - (sw_shadow >> sw_shift)
                      : {1'b0, sw_shadow} + (sw_shadow >> sw_shift);
          if (nf > 12'h7FF) voice_on[0] = 0;
          else begin
            sw_shadow = nf[10:0];
            freq[0] = nf[10:0];
          end
        end
      end
    end else if (seq_pos == 7) begin
      env_tick(0); env_tick(1); env_tick(2);
    end
    seq_pos = seq_pos + 1;
  endfunction

  function automatic void voices_advance();
    bit fb;
    for (int c = 0; c < 2; c++) begin
      if (freq_timer[c] > 0) freq_timer[c]--;
      if (freq_timer[c] == 0) begin
        freq_timer[c] = pulse_reload(freq[c]);
        duty_pos[c] = duty_pos[c] + 1;
      end
    end
    if (freq_timer[2] > 0) freq_timer[2]--;
    if (freq_timer[2] == 0) begin
      freq_timer[2] = wave_reload(freq[2]);
      wpos = wpos + 1;
    end
    if (lfsr_timer > 0) lfsr_timer--;
    if (lfsr_timer == 0) begin
      lfsr_timer = lfsr_reload();
      fb = lfsr[0] ^ lfsr[1];
      lfsr = {fb, lfsr[14:1]};
      if (lfsr_short) lfsr[6] = fb;
    end
  endfunction

  function automatic int clip16(int x);
    return x < -32768 ? -32768 : (x > 32767 ? 32767 : x);
  endfunction

  function automatic sound_result_t mix_sample();
    sound_result_t r;
    int raw[4];
    int lv, rv, l, rt, st, acc;
    bit [7:0] pat;
    bit [3:0] nib;
    acc = 0;
    for (int c = 0; c < 2; c++) begin
      case (duty_sel[c])
        2'd0: pat = 8'h80;
        2'd1: pat = 8'hC0;
        2'd2: pat = 8'hF0;
        default: pat = 8'h3F;
      endcase
      if (!pwr_on || !voice_on[c] || !dac_en[c] || vol[c] == 0) raw[c] = 0;
      else raw[c] = pat[duty_pos[c]] ? int'(vol[c]) : -int'(vol[c]);
    end
    if (!pwr_on || !voice_on[2] || !dac_en[2] || wlevel == 0) raw[2] = 0;
    else begin
      nib = wpos[0] ? wram[wpos[4:1]][3:0] : wram[wpos[4:1]][7:4];
      nib = nib >> (wlevel - 1);
      raw[2] = (int'(nib) - 8) * 2;
    end
    if (!pwr_on || !voice_on[3] || !dac_en[3] || vol[2] == 0) raw[3] = 0;
    else raw[3] = lfsr[0] ? -int'(vol[2]) : int'(vol[2]);
    lv = int'(master_vol[6:4]) + 1;
    rv = int'(master_vol[2:0]) + 1;
    r = '0;
    for (int v = 0; v < 4; v++) begin
      l = routing[4 + v] ? raw[v] : 0;
      rt = routing[v] ? raw[v] : 0;
      st = clip16((l * lv + rt * rv) * 32);
      acc += st;
      case (v)
        0: r.p1 = 16'(st);
        1: r.p2 = 16'(st);
        2: r.wv = 16'(st);
        default: r.nz = 16'(st);
      endcase
    end
    r.mix = 16'(clip16(acc));
    return r;
  endfunction

  function automatic void set_env(int c, int e, bit [7:0] v);
    dac_en[c] = (v & 8'hF8) != 0;
    if (!dac_en[c]) voice_on[c] = 0;
    vol_up[e] = v[3];
    vol_period[e] = v[2:0];
    vol_init[e] = v[7:4];
    vol[e] = v[7:4];
    vol_timer[e] = v[2:0];
  endfunction

  function automatic void pulse_ctrl(int c, bit [7:0] v);
    freq[c] = {v[2:0], freq[c][7:0]};
    len_en[c] = v[6];
    if (v[7]) begin
      if (len_cnt[c] == 0) len_cnt[c] = 64;
      vol[c] = vol_init[c];
      vol_timer[c] = vol_period[c];
      duty_pos[c] = 0;
      freq_timer[c] = pulse_reload(freq[c]);
      voice_on[c] = dac_en[c];
      if (c == 0) begin
        sw_act = sw_period != 0 || sw_shift != 0;
        sw_shadow = freq[0];
        sw_timer = sw_period;
      end
    end
  endfunction

  function automatic void reg_write(bit [15:0] a, bit [7:0] v);
    if (a[15:4] == ADDR_WAVE_PAGE) begin
      wram[a[3:0]] = v;
      return;
    end
    if (a == ADDR_POWER) begin
      pwr_on = v[7];
      if (!pwr_on) clear_voices();
      return;
    end
    if (!pwr_on) return;
    case (a)
      ADDR_SWEEP: begin
        sw_period = v[6:4]; sw_neg = v[3]; sw_shift = v[2:0];
        sw_act = sw_period != 0 || sw_shift != 0;
      end
      ADDR_P1_LEN: begin duty_sel[0] = v[7:6]; len_cnt[0] = 9'(64 - v[5:0]); end
      ADDR_P2_LEN: begin duty_sel[1] = v[7:6]; len_cnt[1] = 9'(64 - v[5:0]); end
      ADDR_P1_ENV: set_env(0, 0, v);
      ADDR_P2_ENV: set_env(1, 1, v);
      ADDR_NOISE_ENV: set_env(3, 2, v);
      ADDR_P1_LO: freq[0][7:0] = v;
      ADDR_P2_LO: freq[1][7:0] = v;
      ADDR_WAVE_LO: freq[2][7:0] = v;
      ADDR_P1_HI: pulse_ctrl(0, v);
      ADDR_P2_HI: pulse_ctrl(1, v);
      ADDR_WAVE_DAC: begin
        dac_en[2] = v[7];
        if (!dac_en[2]) voice_on[2] = 0;
      end
      ADDR_WAVE_LEN: len_cnt[2] = 9'(256 - v);
      ADDR_WAVE_LVL: wlevel = v[6:5];
      ADDR_WAVE_HI: begin
        freq[2] = {v[2:0], freq[2][7:0]};
        len_en[2] = v[6];
        if (v[7]) begin
          if (len_cnt[2] == 0) len_cnt[2] = 256;
          voice_on[2] = dac_en[2];
          freq_timer[2] = wave_reload(freq[2]);
          wpos = 0;
        end
      end
      ADDR_NOISE_LEN: len_cnt[3] = 9'(64 - v[5:0]);
      ADDR_NOISE_POLY: begin lfsr_shift = v[7:4]; lfsr_code = v[2:0]; lfsr_short = v[3]; end
      ADDR_NOISE_CTRL: begin
        len_en[3] = v[6];
        if (v[7]) begin
          if (len_cnt[3] == 0) len_cnt[3] = 64;
          voice_on[3] = dac_en[3];
          vol[2] = vol_init[2];
          vol_timer[2] = vol_period[2];
          lfsr = LFSR_SEED;
          lfsr_timer = lfsr_reload();
        end
      end
      ADDR_MIX_VOL: master_vol = v;
      ADDR_MIX_ROUTE: routing = v;
      default: ;
    endcase
  endfunction

  function automatic bit [7:0] reg_read(bit [15:0] a);
    if (a == ADDR_MIX_VOL) return master_vol;
    if (a == ADDR_MIX_ROUTE) return routing;
    if (a == ADDR_POWER)
      return STATUS_FILL | {pwr_on, 3'b000, voice_on[3], voice_on[2], voice_on[1], voice_on[0]};
    if (a[15:4] == ADDR_WAVE_PAGE) return wram[a[3:0]];
    return READ_NONE;
  endfunction

  // Apply one accepted transaction; return 1 with the expected result if it makes one
  function automatic bit sound_step(bit [1:0] cmd, bit [15:0] a, bit [7:0] d,
                                    output sound_result_t r);
    r = '0;
    if (cmd == CMD_WRITE) begin
      reg_write(a, d);
      return 0;
    end
    if (cmd == CMD_READ) begin
      r.kind = 1'b1;
      r.rd = reg_read(a);
      return 1;
    end
    if (cmd != CMD_TICK) return 0;
    if (pwr_on) begin
      seq_count = seq_count + 1;
      if (seq_count >= seq_period) begin
        seq_count = 0;
        frame_advance();
      end
      voices_advance();
    end
    phase_acc = phase_acc + rate_step;
    if (phase_acc >= rate_mod) begin
      phase_acc = phase_acc % rate_mod;
      r = mix_sample();
      return 1;
    end
    return 0;
  endfunction

  // ---------------- monitor and checker ----------------
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    sound_result_t exp_r, got;
    bit made;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        made = sound_step(command_i, address_i, write_data_i, exp_r);
        if (made && row_typed) exp_r.rd = row_rd;
        if (made) expected_q.push_back(exp_r);
      end
      if (out_valid_o && !out_stall_i) begin
        got = '{result_kind_o, read_data_o, mixed_sample_o, pulse_one_stem_o,
                pulse_two_stem_o, wave_stem_o, noise_stem_o};
        if (expected_q.size() == 0) begin
          error_count++;
          if (error_count <= 10) $display("ERROR: unexpected result %h", got);
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            error_count++;
            if (error_count <= 10)
              $display("ERROR: kind %0d/%0d rd %h/%h mix %h/%h p1 %h/%h p2 %h/%h wv %h/%h nz %h/%h",
                       exp_r.kind, got.kind, exp_r.rd, got.rd, exp_r.mix, got.mix,
                       exp_r.p1, got.p1, exp_r.p2, got.p2, exp_r.wv, got.wv,
                       exp_r.nz, got.nz);
          end
        end
      end
      // watchdog on transactions in either direction
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------- receiver ----------------
  int unsigned recv_pct = 0;
  int unsigned holdoff_left = 0;

  always @(negedge clk_i) begin
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= recv_pct > 0 && $urandom_range(99) < recv_pct;
    end
  end

  // ---------------- sender ----------------
  int unsigned send_pct = 0;

  task automatic send_item(logic [1:0] cmd, logic [15:0] a, logic [7:0] d,
                           logic typed = 1'b0, logic [7:0] rd = 8'h00);
    @(negedge clk_i);
    while (send_pct > 0 && $urandom_range(99) < send_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    address_i <= a;
    write_data_i <= d;
    row_typed <= typed;
    row_rd <= rd;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  task automatic cfg_write(cfg_e idx, logic [31:0] v);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      CFG_SAMPLE_STEP: rate_step = v[21:0];
      CFG_SAMPLE_MOD:  rate_mod = v[23:0];
      default:         seq_period = v[15:0];
    endcase
  endtask

  // Drop valid, wait for all results, then give a slow tick time to finish
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    row_typed <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // One random transaction, or a well-formed voice setup with a trigger, then a mixer write
  task automatic random_items(output int unsigned sent);
    int unsigned r, v;
    logic [15:0] a;
    logic [7:0]  d;
    r = $urandom_range(99);
    sent = 1;
    if (r < 12) begin
      v = $urandom_range(3);
      sent = 4;
      case (v)
        0: begin
          send_item(CMD_WRITE, ADDR_SWEEP, 8'($urandom));
          send_item(CMD_WRITE, ADDR_P1_ENV, 8'($urandom) | 8'h10);
          send_item(CMD_WRITE, ADDR_P1_LO, 8'($urandom));
          send_item(CMD_WRITE, ADDR_P1_HI, 8'($urandom) | 8'h84);
        end
        1: begin
          send_item(CMD_WRITE, ADDR_P2_LEN, 8'($urandom));
          send_item(CMD_WRITE, ADDR_P2_ENV, 8'($urandom) | 8'h10);
          send_item(CMD_WRITE, ADDR_P2_LO, 8'($urandom));
          send_item(CMD_WRITE, ADDR_P2_HI, 8'($urandom) | 8'h84);
        end
        2: begin
          send_item(CMD_WRITE, ADDR_WAVE_DAC, 8'h80);
          send_item(CMD_WRITE, ADDR_WAVE_LVL, 8'($urandom));
          send_item(CMD_WRITE, ADDR_WAVE_LO, 8'($urandom));
          send_item(CMD_WRITE, ADDR_WAVE_HI, 8'($urandom) | 8'h84);
        end
        default: begin
          send_item(CMD_WRITE, ADDR_NOISE_ENV, 8'($urandom) | 8'h10);
          send_item(CMD_WRITE, ADDR_NOISE_POLY, 8'($urandom) & 8'h3F);
          send_item(CMD_WRITE, ADDR_NOISE_LEN, 8'($urandom));
          send_item(CMD_WRITE, ADDR_NOISE_CTRL, 8'($urandom) | 8'h80);
        end
      endcase
      send_item(CMD_WRITE, ($urandom_range(1) ? ADDR_MIX_VOL : ADDR_MIX_ROUTE), 8'($urandom));
      sent = 5;
    end else begin
      a = ($urandom_range(9) < 8) ? 16'($urandom_range(16'hFF10, 16'hFF3F)) : 16'($urandom);
      d = 8'($urandom);
      // power off now and then, mostly keep it on
      if (a == ADDR_POWER && $urandom_range(7) != 0) d[7] = 1'b1;
      if (r < 62) send_item(CMD_TICK, 16'($urandom), 8'($urandom));
      else if (r < 80) send_item(CMD_WRITE, a, d);
      else if (r < 96) send_item(CMD_READ, a, d);
      else begin
        send_item(CMD_UNUSED, a, d);
        sent = 0;
      end
    end
  endtask

  stim_row_t dir_rows[] = '{
    '{CMD_READ,   ADDR_POWER,      8'h00, 1'b1, 8'hF0},
    '{CMD_READ,   ADDR_MIX_VOL,    8'h00, 1'b1, 8'h00},
    '{CMD_READ,   16'h0000,        8'h00, 1'b1, READ_NONE},
    '{CMD_READ,   16'hFFFF,        8'hFF, 1'b1, READ_NONE},
    '{CMD_READ,   16'hFF30,        8'h00, 1'b1, 8'h00},
    '{CMD_UNUSED, ADDR_MIX_VOL,    8'hAA, 1'b0, 8'h00},
    '{CMD_READ,   ADDR_MIX_VOL,    8'h00, 1'b1, 8'h00},
    '{CMD_WRITE,  ADDR_MIX_VOL,    8'h77, 1'b0, 8'h00},
    '{CMD_WRITE,  ADDR_MIX_ROUTE,  8'hFF, 1'b0, 8'h00},
    '{CMD_WRITE,  16'hFF30,        8'hF0, 1'b0, 8'h00},
    '{CMD_WRITE,  ADDR_P1_ENV,     8'hF8, 1'b0, 8'h00},
    '{CMD_WRITE,  ADDR_P1_LEN,     8'h80, 1'b0, 8'h00},
    '{CMD_WRITE,  ADDR_SWEEP,      8'h7F, 1'b0, 8'h00},
    '{CMD_WRITE,  ADDR_P1_HI,      8'h87, 1'b0, 8'h00},
    '{CMD_WRITE,  ADDR_P2_ENV,     8'h08, 1'b0, 8'h00},
    '{CMD_WRITE,  ADDR_WAVE_DAC,   8'h80, 1'b0, 8'h00},
    '{CMD_WRITE,  ADDR_WAVE_LVL,   8'h20, 1'b0, 8'h00},
    '{CMD_WRITE,  ADDR_WAVE_HI,    8'h87, 1'b0, 8'h00},
    '{CMD_WRITE,  ADDR_NOISE_ENV,  8'hF0, 1'b0, 8'h00},
    '{CMD_WRITE,  ADDR_NOISE_POLY, 8'h08, 1'b0, 8'h00},
    '{CMD_WRITE,  ADDR_NOISE_CTRL, 8'hC0, 1'b0, 8'h00},
    '{CMD_READ,   ADDR_POWER,      8'h00, 1'b0, 8'h00},
    '{CMD_WRITE,  ADDR_POWER,      8'h00, 1'b0, 8'h00},
    '{CMD_READ,   ADDR_POWER,      8'h00, 1'b1, STATUS_FILL},
    '{CMD_READ,   16'hFF30,        8'h00, 1'b1, 8'hF0},
    '{CMD_WRITE,  ADDR_MIX_VOL,    8'h12, 1'b0, 8'h00},
    '{CMD_READ,   ADDR_MIX_VOL,    8'h00, 1'b1, 8'h00},
    '{CMD_WRITE,  ADDR_POWER,      8'h80, 1'b0, 8'h00}
  };

  // per phase: sample step, modulus, frame period, sender and receiver idle, length
  int unsigned ph_step[7]  = '{1, 3, 4194303, 5000,     1, 2, 40000};
  int unsigned ph_mod[7]   = '{2, 7, 1,       16777215, 1, 5, 65536};
  int unsigned ph_frame[7] = '{1, 4, 3,       65535,    2, 7, 5};
  int unsigned ph_send[7]  = '{67, 0, 27, 0,  67, 0,  27};
  int unsigned ph_recv[7]  = '{0, 0, 27, 0,   0,  67, 27};
  int unsigned ph_len[7]   = '{230, 230, 120, 120, 230, 230, 230};

  initial begin
    int unsigned sent, n;
    rate_step = 48000; rate_mod = 4194304; seq_period = 8192;
    pwr_on = 1'b1; seq_count = 0; seq_pos = 0; phase_acc = 0;
    clear_voices();
    foreach (wram[i]) wram[i] = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table under reset settings, a tick after every fourth row
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].cmd, dir_rows[i].addr, dir_rows[i].data,
                dir_rows[i].typed, dir_rows[i].rd);
      if (i % 4 == 3) send_item(CMD_TICK, 16'h0000, 8'h00);
    end
    n = 0;
    while (n < 200) begin
      random_items(sent);
      n += sent;
    end

    // random phases with their own rate settings and idle profiles
    for (int p = 0; p < 7; p++) begin
      drain();
      cfg_write(CFG_SAMPLE_STEP, ph_step[p]);
      cfg_write(CFG_SAMPLE_MOD, ph_mod[p]);
      cfg_write(CFG_FRAME_STEP, ph_frame[p]);
      send_pct = ph_send[p];
      recv_pct = (p == 1) ? 0 : ph_recv[p];
      if (p == 3) recv_pct = 67;
      if (p == 1) holdoff_left = HOLDOFF_CYCLES;
      n = 0;
      while (n < ph_len[p]) begin
        random_items(sent);
        n += sent;
      end
    end

    drain();
    if (error_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
